FILE: rtl/prk_pkg.sv
// Shared constants and controller/datapath interface types for the percentile
// rank engine. No dependencies.
package prk_pkg;

  localparam int MAX_POINTS    = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DCNT_W = $clog2(FRACTION_BITS);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // take the request on the input channel
    logic fetch;      // read the current point's sample
    logic latch;      // hold that sample, start the scan at index 0
    logic scan;       // compare one stored sample per cycle
    logic div_start;  // load the divider with the finished rank
    logic div_step;   // one quotient bit
    logic emit_done;  // result taken, advance or clear
  } prk_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic run_last;
  } prk_sts_t;

endpackage

FILE: rtl/prk_dpath.sv
// Datapath of the percentile rank engine: sample memory, load counter, rank
// scan and the bit-serial percentile divider. Depends on prk_pkg.
module prk_dpath import prk_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  prk_cmd_t                 cmd_i,
  output prk_sts_t                 sts_o,
  input  logic [SAMPLE_BITS-1:0]   sample_value_i,
  output logic [IDX_W-1:0]         point_index_o,
  output logic [IDX_W-1:0]         point_rank_o,
  output logic [FRACTION_BITS-1:0] percentile_o,
  output logic                     overflow_flag_o
);

  logic [SAMPLE_BITS-1:0] mem [MAX_POINTS];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [IDX_W-1:0]       raddr;

  logic [CNT_W-1:0] count_q, count_d;
  logic             dropped_q, dropped_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic             p_q, p_d;
  logic [IDX_W-1:0] pj_q, pj_d;
  logic [SAMPLE_BITS-1:0] v_q, v_d;
  logic [IDX_W-1:0] rank_q, rank_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [FRACTION_BITS-1:0] quo_q, quo_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;

  logic             store_full;
  logic             smaller;
  logic [CNT_W:0]   rem_sh;
  logic             qbit;

  assign store_full = (count_q == CNT_W'(MAX_POINTS));
  assign smaller    = (rd_q < v_q) || ((rd_q == v_q) && (pj_q < i_q));
  assign rem_sh     = {rem_q, 1'b0};
  assign qbit       = (rem_sh >= {1'b0, count_q});

  always_comb begin
    if (cmd_i.fetch) begin
      raddr = i_q;
    end else if (cmd_i.latch) begin
      raddr = '0;
    end else begin
      raddr = j_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !store_full) begin
      mem[count_q[IDX_W-1:0]] <= sample_value_i;
    end
    rd_q <= mem[raddr];
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    i_d       = i_q;
    j_d       = j_q;
    p_d       = p_q;
    pj_d      = pj_q;
    v_d       = v_q;
    rank_d    = rank_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dcnt_d    = dcnt_q;

    if (cmd_i.accept) begin
      if (store_full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end

    if (cmd_i.latch) begin
      v_d    = rd_q;
      rank_d = '0;
      j_d    = CNT_W'(1);
      p_d    = 1'b1;
      pj_d   = '0;
    end

    if (cmd_i.scan) begin
      if (p_q && smaller) begin
        rank_d = rank_q + IDX_W'(1);
      end
      if (j_q != count_q) begin
        p_d  = 1'b1;
        pj_d = j_q[IDX_W-1:0];
        j_d  = j_q + CNT_W'(1);
      end else begin
        p_d = 1'b0;
      end
    end

    if (cmd_i.div_start) begin
      rem_d  = CNT_W'(rank_q);
      quo_d  = '0;
      dcnt_d = '0;
    end

    if (cmd_i.div_step) begin
      if (qbit) begin
        rem_d = CNT_W'(rem_sh - {1'b0, count_q});
      end else begin
        rem_d = rem_sh[CNT_W-1:0];
      end
      quo_d  = {quo_q[FRACTION_BITS-2:0], qbit};
      dcnt_d = dcnt_q + DCNT_W'(1);
    end

    if (cmd_i.emit_done) begin
      if (sts_o.run_last) begin
        count_d   = '0;
        dropped_d = 1'b0;
        i_d       = '0;
      end else begin
        i_d = i_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      i_q       <= '0;
      p_q       <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      i_q       <= i_d;
      p_q       <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    pj_q   <= pj_d;
    v_q    <= v_d;
    rank_q <= rank_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dcnt_q <= dcnt_d;
  end

  assign sts_o.scan_done = (j_q == count_q) && !p_q;
  assign sts_o.div_done  = (dcnt_q == DCNT_W'(FRACTION_BITS - 1));
  assign sts_o.run_last  = ({1'b0, i_q} + CNT_W'(1)) == count_q;

  assign point_index_o   = i_q;
  assign point_rank_o    = rank_q;
  assign percentile_o    = quo_q;
  assign overflow_flag_o = dropped_q;

endmodule

FILE: rtl/prk_ctrl.sv
// Controller of the percentile rank engine: load, fetch, scan, divide and
// emit sequence. Depends on prk_pkg.
module prk_ctrl import prk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     last_sample_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  prk_sts_t sts_i,
  output prk_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_FETCH = 6'b000010,
    ST_LATCH = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_EMIT  = 6'b100000
  } prk_state_e;

  prk_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && last_sample_i) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_LATCH;
      end
      ST_LATCH: begin
        cmd_o.latch = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_done = 1'b1;
          state_d = sts_i.run_last ? ST_LOAD : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/percentile_rank_engine_core.sv
// Top level of the percentile rank engine: joins the controller and the
// datapath. Depends on prk_pkg, prk_ctrl and prk_dpath.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one sample request per
//   cycle while loading. A request with last_sample_i set closes the series
//   and starts ranking; no input is taken until every result is delivered.
//   Samples beyond MAX_POINTS are dropped and overflow_flag_o is set on all
//   results of that series.
//   Output channel (out_valid_o / out_ready_i) carries one result per stored
//   point, in original order, last_result_o set on the final one.
// Per-point sequence:
//   After loading, each point first fetches its sample through the single
//   read port of the sample memory, then scans the memory one entry per
//   cycle, then runs the bit-serial divider (one quotient bit per cycle,
//   16 bits), and then holds the result until it is handed over.
// Reset and stalls:
//   Reset clears the load count, drop mark and controller; memory contents
//   need no clearing. While out_ready_i is low the result holds steady and
//   the sequence waits.
module percentile_rank_engine_core import prk_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_value_i,
  input  logic                     last_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IDX_W-1:0]         point_index_o,
  output logic [IDX_W-1:0]         point_rank_o,
  output logic [FRACTION_BITS-1:0] percentile_o,
  output logic                     overflow_flag_o,
  output logic                     last_result_o
);

  prk_cmd_t cmd;
  prk_sts_t sts;

  // Sequence control: load, then per point fetch / scan / divide / emit
  prk_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Storage, rank counting and percentile division
  prk_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sample_value_i  (sample_value_i),
    .point_index_o   (point_index_o),
    .point_rank_o    (point_rank_o),
    .percentile_o    (percentile_o),
    .overflow_flag_o (overflow_flag_o)
  );

  // Final result of the run is the one for the last stored point
  assign last_result_o = sts.run_last;

endmodule

FILE: dv/percentile_rank_engine_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for percentile_rank_engine_core: random sample series with
// predicted rank and percentile per point. Depends on prk_pkg and the engine RTL.
module percentile_rank_engine_core_tb;
  import prk_pkg::*;

  localparam int unsigned RUN_ITEMS    = 500;
  localparam int unsigned PHASE_ITEMS  = 40;      // requests per idling phase
  localparam int unsigned HOLD_AT      = 150;     // requests before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 20000000;

  typedef enum int unsigned {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE
  } idle_phase_e;

  // How the values of one series are drawn
  typedef enum int unsigned {
    VALS_FULL,
    VALS_NARROW,
    VALS_EXTREME,
    VALS_CLUSTER
  } value_mode_e;

  typedef struct {
    logic [SAMPLE_BITS-1:0] value;
    logic                   closes;
  } sample_req_t;

  typedef struct {
    logic [IDX_W-1:0]         index;
    logic [IDX_W-1:0]         rank;
    logic [FRACTION_BITS-1:0] pct;
    logic                     ovf;
    logic                     fin;
  } point_t;

  logic                     clk_i;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [SAMPLE_BITS-1:0]   sample_value_i = '0;
  logic                     last_sample_i  = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic [IDX_W-1:0]         point_index_o;
  logic [IDX_W-1:0]         point_rank_o;
  logic [FRACTION_BITS-1:0] percentile_o;
  logic                     overflow_flag_o;
  logic                     last_result_o;

  sample_req_t sample_reqs[$];     // requests not yet offered
  point_t      pending_points[$];  // predicted results, oldest first

  // Predictor copy of the engine's series store
  logic [SAMPLE_BITS-1:0] series_samples[MAX_POINTS];
  int unsigned            series_len     = 0;
  logic                   series_dropped = 1'b0;

  int unsigned n_total    = 0;
  int unsigned n_accepted = 0;
  int unsigned n_fail     = 0;
  int unsigned n_cycles   = 0;
  bit          in_taken   = 1'b0;
  bit          hold_off   = 1'b0;

  percentile_rank_engine_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_value_i (sample_value_i),
    .last_sample_i  (last_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_index_o  (point_index_o),
    .point_rank_o   (point_rank_o),
    .percentile_o   (percentile_o),
    .overflow_flag_o(overflow_flag_o),
    .last_result_o  (last_result_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Idle percentage of one side for the current phase; phases rotate with
  // the number of accepted requests.
  function automatic int unsigned idle_pct(input bit recv_side);
    idle_phase_e ph;
    ph = idle_phase_e'((n_accepted / PHASE_ITEMS) % 4);
    case (ph)
      PH_SEND_IDLE:  return recv_side ? 0 : 75;
      PH_RECV_STALL: return recv_side ? 75 : 0;
      PH_BOTH_IDLE:  return 11;
      default:       return 0;
    endcase
  endfunction

  // Store one accepted sample; on the closing sample, rank the whole series
  // and queue one expected point per stored sample in original order.
  task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] value, input logic closes);
    int unsigned       rank;
    longint unsigned   scaled;
    point_t            pt;
    if (series_len < MAX_POINTS) begin
      series_samples[series_len] = value;
      series_len++;
    end else begin
      series_dropped = 1'b1;
    end
    if (closes) begin
      for (int i = 0; i < series_len; i++) begin
        rank = 0;
        // smaller samples, plus equal ones at an earlier index
        for (int j = 0; j < series_len; j++) begin
          if (series_samples[j] < series_samples[i] ||
              (series_samples[j] == series_samples[i] && j < i)) begin
            rank++;
          end
        end
        scaled   = (longint'(rank) << FRACTION_BITS) / series_len;
        pt.index = i[IDX_W-1:0];
        pt.rank  = rank[IDX_W-1:0];
        pt.pct   = scaled[FRACTION_BITS-1:0];
        pt.ovf   = series_dropped;
        pt.fin   = (i + 1 == series_len);
        pending_points.push_back(pt);
      end
      series_len     = 0;
      series_dropped = 1'b0;
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  task automatic add_req(input logic [SAMPLE_BITS-1:0] value, input logic closes);
    sample_req_t req;
    req.value  = value;
    req.closes = closes;
    sample_reqs.push_back(req);
  endtask

  task automatic add_series(input int unsigned len, input value_mode_e mode);
    logic [SAMPLE_BITS-1:0] v;
    for (int k = 0; k < len; k++) begin
      case (mode)
        VALS_NARROW:  v = SAMPLE_BITS'($urandom_range(0, 3));
        VALS_EXTREME: v = $urandom_range(0, 1) ? '1 : '0;
        VALS_CLUSTER: v = SAMPLE_BITS'($urandom_range(32760, 32775));
        default:      v = SAMPLE_BITS'($urandom_range(0, 65535));
      endcase
      add_req(v, k == len - 1);
    end
  endtask

  // Driver: offer requests at the falling edge, hold each until it is taken.
  always @(negedge clk_i) begin : drive
    sample_req_t req;
    bit          holding;
    if (rst_ni) begin
      holding = in_valid_i && !in_taken;
      if (!holding) begin
        if (sample_reqs.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          req = sample_reqs.pop_front();
          in_valid_i     <= 1'b1;
          sample_value_i <= req.value;
          last_sample_i  <= req.closes;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, and all the time during the long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= !hold_off && ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // Monitor: check delivered points against the oldest prediction, then
  // feed the predictor with any request taken at this edge.
  always @(posedge clk_i) begin : watch
    point_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_points.size() == 0) begin
          $error("unexpected result: point_index %0d, point_rank %0d",
                 point_index_o, point_rank_o);
          n_fail++;
        end else begin
          want = pending_points.pop_front();
          check_field("point_index", 32'(want.index), 32'(point_index_o));
          check_field("point_rank", 32'(want.rank), 32'(point_rank_o));
          check_field("percentile", 32'(want.pct), 32'(percentile_o));
          check_field("overflow_flag", 32'(want.ovf), 32'(overflow_flag_o));
          check_field("last_result", 32'(want.fin), 32'(last_result_o));
        end
      end
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        absorb_sample(sample_value_i, last_sample_i);
        n_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Long receiver hold-off: the engine sits on a result and refuses input
  // while the driver keeps offering.
  initial begin
    wait (n_accepted >= HOLD_AT);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin : main
    int unsigned pick;
    int unsigned len;
    value_mode_e mode;

    // Directed: single points at both extremes
    add_req('0, 1'b1);
    add_req('1, 1'b1);
    // extremes with ties in both directions
    add_req('1, 1'b0);
    add_req('0, 1'b0);
    add_req('1, 1'b0);
    add_req('0, 1'b0);
    add_req(16'h8000, 1'b1);
    // alternating bit patterns, repeated
    add_req(16'hAAAA, 1'b0);
    add_req(16'h5555, 1'b0);
    add_req(16'h5555, 1'b0);
    add_req(16'hAAAA, 1'b1);
    // all equal: rank follows index
    for (int k = 0; k < 4; k++) add_req(16'h1234, k == 3);
    // strictly descending
    for (int k = 0; k < 5; k++) add_req(SAMPLE_BITS'(400 - 100 * k), k == 4);

    // Store full: exactly full, then overflow with the closing sample dropped
    add_series(MAX_POINTS, VALS_FULL);
    add_series(MAX_POINTS + 2, VALS_NARROW);

    // Random series, mostly short
    while (sample_reqs.size() < RUN_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 80)      len = $urandom_range(1, 12);
      else if (pick < 90) len = $urandom_range(13, 40);
      else if (pick < 94) len = MAX_POINTS;
      else if (pick < 97) len = MAX_POINTS - 1;
      else                len = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
      mode = value_mode_e'($urandom_range(0, 3));
      add_series(len, mode);
    end
    n_total = sample_reqs.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (n_accepted == n_total);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_fail == 0 && pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/prk_pkg.sv
rtl/prk_dpath.sv
rtl/prk_ctrl.sv
rtl/percentile_rank_engine_core.sv
dv/percentile_rank_engine_core_tb.sv
